FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Each macro is a complete concurrent assertion on clk_i, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: sv/anp_pkg.sv
`default_nettype none

package anp_pkg;

  // Segment geometry.
  localparam int SEGMENT_CHARS = 4;
  localparam int CIS_W         = $clog2(SEGMENT_CHARS);

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  // Reset value of the capacity register.
  localparam logic [15:0] CAP_RESET = 16'd256;

  // AML prefix bytes.
  localparam logic [7:0] ROOT_BYTE   = 8'h5C;
  localparam logic [7:0] PARENT_BYTE = 8'h5E;
  localparam logic [7:0] DUAL_BYTE   = 8'h2E;
  localparam logic [7:0] MULTI_BYTE  = 8'h2F;
  localparam logic [7:0] NULL_BYTE   = 8'h00;

  // Text characters.
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_US     = 8'h5F;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_BOUNDS = 2'd2
  } status_e;

  // One classified input word.
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       bl_zero;
    logic       bl_short;
    logic       is_root;
    logic       is_parent;
    logic       is_dual;
    logic       is_multi;
    logic       is_null;
    logic       lead_ok;
    logic       body_ok;
  } cls_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cls_t cls;
  } fe_item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic [1:0] status;
    logic       done;
  } res_t;

  // Zero, one or two result words written in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_push_t;

  // Result queue status.
  typedef struct packed {
    logic empty;
    logic space2;
  } oq_stat_t;

  function automatic logic is_lead(input logic [7:0] c);
    return ((c >= CHAR_A) && (c <= CHAR_Z)) || (c == CHAR_US);
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return is_lead(c) || ((c >= CHAR_0) && (c <= CHAR_9));
  endfunction

endpackage

`default_nettype wire

FILE: sv/anp_front.sv
`default_nettype none

module anp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire logic            start_req_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic [31:0]     bytes_left_i,
  output anp_pkg::fe_item_t    head_o,
  input  wire logic            pop_i
);
  import anp_pkg::*;

  cls_t       mem_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok;
  logic       pop_ok;
  cls_t       cls_in;

  // Classify the incoming byte.
  always_comb begin
    cls_in.start     = start_req_i;
    cls_in.data      = in_byte_i;
    cls_in.bl_zero   = (bytes_left_i == 32'd0);
    cls_in.bl_short  = (bytes_left_i < 32'(SEGMENT_CHARS));
    cls_in.is_root   = (in_byte_i == ROOT_BYTE);
    cls_in.is_parent = (in_byte_i == PARENT_BYTE);
    cls_in.is_dual   = (in_byte_i == DUAL_BYTE);
    cls_in.is_multi  = (in_byte_i == MULTI_BYTE);
    cls_in.is_null   = (in_byte_i == NULL_BYTE);
    cls_in.lead_ok   = is_lead(in_byte_i);
    cls_in.body_ok   = is_body(in_byte_i);
  end

  assign full_o  = (cnt_q == 2'd2);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && (cnt_q != 2'd0);

  // Queue pointers and fill count.
  always_comb begin
    wp_d  = push_ok ? ~wp_q : wp_q;
    rp_d  = pop_ok ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wp_q] <= cls_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cls   = mem_q[rp_q];

endmodule

`default_nettype wire

FILE: sv/anp_back.sv
`default_nettype none

module anp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [15:0]          out_capacity_i,
  input  wire anp_pkg::fe_item_t    head_i,
  output logic                      pop_o,
  input  wire anp_pkg::oq_stat_t    oq_stat_i,
  output anp_pkg::res_push_t        res_push_o
);
  import anp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PARENTS,
    PH_AFTER_ROOT,
    PH_MULTI_COUNT,
    PH_SEGMENT
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [15:0]      cw_q, cw_d;
  logic [7:0]       sl_q, sl_d;
  logic [CIS_W-1:0] cis_q, cis_d;
  logic             fs_q, fs_d;

  cls_t             c;
  logic             take;
  logic             act_parent;
  logic             act_name;
  logic             act_seg;
  logic             char_go;
  logic             dot_en;
  logic             m_en;
  res_t             mr;
  logic [CIS_W:0]   cis_inc;

  assign c     = head_i.cls;
  assign take  = head_i.valid && oq_stat_i.space2;
  assign pop_o = take;

  // Per-byte decision.
  always_comb begin
    phase_d    = phase_q;
    cw_d       = cw_q;
    sl_d       = sl_q;
    cis_d      = cis_q;
    fs_d       = fs_q;
    act_parent = 1'b0;
    act_name   = 1'b0;
    act_seg    = 1'b0;
    char_go    = 1'b0;
    dot_en     = 1'b0;
    m_en       = 1'b0;
    mr         = '0;
    cis_inc    = '0;

    if (take) begin
      if (c.start) begin
        cw_d    = '0;
        sl_d    = '0;
        cis_d   = '0;
        fs_d    = 1'b1;
        phase_d = PH_IDLE;
        if (out_capacity_i < 16'd2) begin
          m_en = 1'b1;
          mr   = '{8'h00, 1'b0, ST_FORMAT, 1'b1};
        end else if (c.bl_zero) begin
          m_en = 1'b1;
          mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
        end else if (c.is_root) begin
          cw_d    = 16'd1;
          phase_d = PH_AFTER_ROOT;
          m_en    = 1'b1;
          mr      = '{CHAR_BSLASH, 1'b1, ST_OK, 1'b0};
        end else if (c.is_parent) begin
          act_parent = 1'b1;
        end else begin
          act_name = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_PARENTS: begin
            if (!c.bl_zero && c.is_parent) begin
              act_parent = 1'b1;
            end else begin
              act_name = 1'b1;
            end
          end
          PH_AFTER_ROOT: begin
            act_name = 1'b1;
          end
          PH_MULTI_COUNT: begin
            if (c.bl_zero) begin
              m_en = 1'b1;
              mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
            end else if (c.is_null) begin
              m_en = 1'b1;
              mr   = '{8'h00, 1'b0, ST_OK, 1'b1};
            end else begin
              sl_d    = c.data;
              fs_d    = 1'b1;
              cis_d   = '0;
              phase_d = PH_SEGMENT;
            end
          end
          PH_SEGMENT: begin
            act_seg = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      // Parent prefix: room for a caret and the terminator.
      if (act_parent) begin
        if (({1'b0, cw_d} + 17'd1) >= {1'b0, out_capacity_i}) begin
          m_en = 1'b1;
          mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
        end else begin
          cw_d    = cw_d + 16'd1;
          phase_d = PH_PARENTS;
          m_en    = 1'b1;
          mr      = '{CHAR_CARET, 1'b1, ST_OK, 1'b0};
        end
      end

      // Name body: null name, dual or multi prefix, or a single segment.
      if (act_name) begin
        if (c.bl_zero) begin
          m_en = 1'b1;
          mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
        end else if (c.is_null) begin
          m_en = 1'b1;
          mr   = '{8'h00, 1'b0, ST_OK, 1'b1};
        end else begin
          fs_d  = 1'b1;
          cis_d = '0;
          if (c.is_dual) begin
            sl_d    = 8'd2;
            phase_d = PH_SEGMENT;
          end else if (c.is_multi) begin
            phase_d = PH_MULTI_COUNT;
          end else if (!c.lead_ok) begin
            m_en = 1'b1;
            mr   = '{8'h00, 1'b0, ST_FORMAT, 1'b1};
          end else begin
            sl_d    = 8'd1;
            phase_d = PH_SEGMENT;
            act_seg = 1'b1;
          end
        end
      end

      // Segment character, with a dot before every segment but the first.
      if (act_seg) begin
        if (cis_d == '0) begin
          if (c.bl_short) begin
            m_en = 1'b1;
            mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
          end else if (({1'b0, cw_d} + 17'(SEGMENT_CHARS + 2)) > {1'b0, out_capacity_i}) begin
            m_en = 1'b1;
            mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
          end else begin
            if (!fs_d) begin
              dot_en = 1'b1;
              cw_d   = cw_d + 16'd1;
            end
            fs_d = 1'b0;
            if (!c.lead_ok) begin
              m_en = 1'b1;
              mr   = '{8'h00, 1'b0, ST_FORMAT, 1'b1};
            end else begin
              char_go = 1'b1;
            end
          end
        end else begin
          if (c.bl_zero) begin
            m_en = 1'b1;
            mr   = '{8'h00, 1'b0, ST_BOUNDS, 1'b1};
          end else if (!c.body_ok) begin
            m_en = 1'b1;
            mr   = '{8'h00, 1'b0, ST_FORMAT, 1'b1};
          end else begin
            char_go = 1'b1;
          end
        end

        if (char_go) begin
          cw_d    = cw_d + 16'd1;
          cis_inc = {1'b0, cis_d} + {{CIS_W{1'b0}}, 1'b1};
          m_en    = 1'b1;
          mr      = '{c.data, 1'b1, ST_OK, 1'b0};
          if (cis_inc == (CIS_W + 1)'(SEGMENT_CHARS)) begin
            cis_d   = '0;
            sl_d    = sl_d - 8'd1;
            mr.done = (sl_d == 8'd0);
          end else begin
            cis_d = cis_inc[CIS_W-1:0];
          end
        end
      end

      // A final result ends the name string.
      if (m_en && mr.done) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // Results toward the output queue: a dot always comes first.
  always_comb begin
    res_push_o.r0  = mr;
    res_push_o.r1  = '0;
    res_push_o.cnt = m_en ? 2'd1 : 2'd0;
    if (dot_en) begin
      res_push_o.r0  = '{CHAR_DOT, 1'b1, ST_OK, 1'b0};
      res_push_o.r1  = mr;
      res_push_o.cnt = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cw_q    <= '0;
      sl_q    <= '0;
      cis_q   <= '0;
      fs_q    <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cw_q    <= cw_d;
      sl_q    <= sl_d;
      cis_q   <= cis_d;
      fs_q    <= fs_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/anp_outq.sv
`default_nettype none

module anp_outq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire anp_pkg::res_push_t   res_push_i,
  output anp_pkg::oq_stat_t         stat_o,
  output anp_pkg::res_t             head_o,
  input  wire logic                 pop_i
);
  import anp_pkg::*;

  res_t                mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp_q, wp_d;
  logic [OQ_PTR_W-1:0] rp_q, rp_d;
  logic [OQ_PTR_W:0]   cnt_q, cnt_d;
  logic [OQ_PTR_W-1:0] wp_next;
  logic                pop_ok;

  assign stat_o.empty  = (cnt_q == '0);
  assign stat_o.space2 = (cnt_q <= (OQ_PTR_W + 1)'(OQ_DEPTH - 2));
  assign pop_ok        = pop_i && !stat_o.empty;
  assign wp_next       = wp_q + {{(OQ_PTR_W-1){1'b0}}, 1'b1};
  assign head_o        = mem_q[rp_q];

  // Pointers and fill count; up to two words enter per cycle.
  always_comb begin
    wp_d  = wp_q + res_push_i.cnt[OQ_PTR_W-1:0];
    rp_d  = pop_ok ? (rp_q + {{(OQ_PTR_W-1){1'b0}}, 1'b1}) : rp_q;
    cnt_d = cnt_q + (OQ_PTR_W + 1)'(res_push_i.cnt) - {{OQ_PTR_W{1'b0}}, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (res_push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= res_push_i.r0;
    end
    if (res_push_i.cnt == 2'd2) begin
      mem_q[wp_next] <= res_push_i.r1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/aml_namestring_parser_top.sv
// ACPI AML name string decoder. Feed one AML byte per word through push/full, with
// start_req_i on the first byte of a name and bytes_left_i counting the stream bytes
// left; decoded text comes out one character per word through empty/pop, and the last
// word of each name carries done_res_o (errors give status 1 for format, 2 for bounds).
// A byte is taken every cycle while the result side keeps up; it is held in the input
// queue until the decoder takes it and writes its first result into the result queue,
// whose head drives the result ports. A byte that yields a dot and a character puts
// two words in the result queue, and the decoder waits whenever that queue has fewer
// than two free slots, which is what raises full. The capacity register (cfg_we_i,
// cfg_wdata_i, reset 256) applies to the checks of the bytes decoded after the write;
// write it while no byte waits inside the block.
`default_nettype none

`include "assert_macros.svh"

module aml_namestring_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic [31:0] bytes_left_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_char_o,
  output logic             char_valid_o,
  output logic [1:0]       status_o,
  output logic             done_res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import anp_pkg::*;

  logic [15:0] cap_q;
  fe_item_t    fe_head;
  logic        fe_pop;
  res_push_t   res_push;
  oq_stat_t    oq_stat;
  res_t        oq_head;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  anp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .start_req_i  (start_req_i),
    .in_byte_i    (in_byte_i),
    .bytes_left_i (bytes_left_i),
    .head_o       (fe_head),
    .pop_i        (fe_pop)
  );

  anp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .out_capacity_i (cap_q),
    .head_i         (fe_head),
    .pop_o          (fe_pop),
    .oq_stat_i      (oq_stat),
    .res_push_o     (res_push)
  );

  anp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .stat_o     (oq_stat),
    .head_o     (oq_head),
    .pop_i      (pop)
  );

  assign empty        = oq_stat.empty;
  assign out_char_o   = oq_head.ch;
  assign char_valid_o = oq_head.valid;
  assign status_o     = oq_head.status;
  assign done_res_o   = oq_head.done;

  // An error word carries no character and closes the name.
  `ASSERT_IMPLY(a_err_word, !empty && (status_o != ST_OK), done_res_o && !char_valid_o)
  // A byte that yields two words always leads with a good dot.
  `ASSERT_IMPLY(a_pair_dot, res_push.cnt == 2'd2,
                res_push.r0.valid && (res_push.r0.ch == CHAR_DOT) && (res_push.r0.status == ST_OK))
  // The decoder never takes a byte without room for two results.
  `ASSERT_NEVER(a_no_room_take, fe_pop && !oq_stat.space2)
  // The decoder only takes a byte that the input queue holds.
  `ASSERT_NEVER(a_take_empty, fe_pop && !fe_head.valid)

endmodule

`default_nettype wire
